### rtl/composite_sync_field_decoder_assert.svh
// ----------------------------------------------------------------------------
// Composite sync field decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef COMPOSITE_SYNC_FIELD_DECODER_ASSERT_SVH
`define COMPOSITE_SYNC_FIELD_DECODER_ASSERT_SVH

// Same-cycle implication.
`define CSFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/csfd_pkg.sv
// ----------------------------------------------------------------------------
// Composite sync field decoder package
// Types, codes and constants shared by the decoder files.
// ----------------------------------------------------------------------------
package csfd_pkg;

  localparam int unsigned PAL_VISIBLE   = 288;
  localparam int unsigned NTSC_VISIBLE  = 240;
  localparam int unsigned FIRST_VISIBLE = 15;

  localparam logic [7:0]  BROAD_PAL  = 8'd5;
  localparam logic [7:0]  BROAD_NTSC = 8'd6;
  localparam logic [7:0]  BROAD_SAT  = 8'hFF;
  localparam logic [9:0]  LINE_SAT   = 10'h3FF;
  localparam logic [15:0] FERR_SAT   = 16'hFFFF;

  localparam logic [15:0] RST_SHORT_MIN     = 16'd120;
  localparam logic [15:0] RST_SHORT_MAX     = 16'd280;
  localparam logic [15:0] RST_HSYNC_MIN     = 16'd300;
  localparam logic [15:0] RST_HSYNC_MAX     = 16'd500;
  localparam logic [15:0] RST_BROAD_MIN     = 16'd1800;
  localparam logic [15:0] RST_BROAD_MAX     = 16'd2500;
  localparam logic [15:0] RST_HALF_LINE_MIN = 16'd1280;
  localparam logic [15:0] RST_HALF_LINE_MAX = 16'd2292;

  typedef enum logic [2:0] {
    ST_WAIT  = 3'd0,
    ST_PRE   = 3'd1,
    ST_SYNC  = 3'd2,
    ST_POST  = 3'd3,
    ST_LINES = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SYS_UNKNOWN = 2'd0,
    SYS_PAL     = 2'd1,
    SYS_NTSC    = 2'd2
  } system_t;

  typedef enum logic [2:0] {
    CFG_SHORT_MIN     = 3'd0,
    CFG_SHORT_MAX     = 3'd1,
    CFG_HSYNC_MIN     = 3'd2,
    CFG_HSYNC_MAX     = 3'd3,
    CFG_BROAD_MIN     = 3'd4,
    CFG_BROAD_MAX     = 3'd5,
    CFG_HALF_LINE_MIN = 3'd6,
    CFG_HALF_LINE_MAX = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] short_min;
    logic [15:0] short_max;
    logic [15:0] hsync_min;
    logic [15:0] hsync_max;
    logic [15:0] broad_min;
    logic [15:0] broad_max;
    logic [15:0] half_line_min;
    logic [15:0] half_line_max;
  } cfg_t;

  typedef struct packed {
    logic        edge_falling;
    logic [15:0] capture_time;
  } item_t;

  typedef struct packed {
    status_t     sync_status;
    system_t     video_system;
    logic        field_type;
    logic [9:0]  line_number;
    logic        next_line_visible;
    logic [9:0]  visible_line_index;
    logic        field_start;
    logic        frame_start;
    logic        pulse_error;
    logic [31:0] valid_frames;
    logic [31:0] total_errors;
  } result_t;

endpackage

### rtl/csfd_if.sv
// ----------------------------------------------------------------------------
// Composite sync field decoder channels
// Valid/ready channels for sync edges in and decoded field status out.
// ----------------------------------------------------------------------------
interface csfd_in_if;
  logic        valid;
  logic        ready;
  logic        edge_falling;
  logic [15:0] capture_time;

  modport source (output valid, output edge_falling, output capture_time, input ready);
  modport sink   (input valid, input edge_falling, input capture_time, output ready);
endinterface

interface csfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  sync_status;
  logic [1:0]  video_system;
  logic        field_type;
  logic [9:0]  line_number;
  logic        next_line_visible;
  logic [9:0]  visible_line_index;
  logic        field_start;
  logic        frame_start;
  logic        pulse_error;
  logic [31:0] valid_frames;
  logic [31:0] total_errors;

  modport source (
    output valid, input ready,
    output sync_status, output video_system, output field_type, output line_number,
    output next_line_visible, output visible_line_index, output field_start,
    output frame_start, output pulse_error, output valid_frames, output total_errors
  );
  modport sink (
    input valid, output ready,
    input sync_status, input video_system, input field_type, input line_number,
    input next_line_visible, input visible_line_index, input field_start,
    input frame_start, input pulse_error, input valid_frames, input total_errors
  );
endinterface

### rtl/csfd_core.sv
// ----------------------------------------------------------------------------
// Composite sync field decoder core
// Classifies one sync pulse per step and updates the field state and counters.
// ----------------------------------------------------------------------------
module csfd_core #(
  parameter int unsigned PAL_VISIBLE   = csfd_pkg::PAL_VISIBLE,
  parameter int unsigned NTSC_VISIBLE  = csfd_pkg::NTSC_VISIBLE,
  parameter int unsigned FIRST_VISIBLE = csfd_pkg::FIRST_VISIBLE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  csfd_pkg::item_t    item,
  input  csfd_pkg::cfg_t     cfg,
  output csfd_pkg::result_t  result
);

  logic [15:0]       last_capture_r, last_capture_nxt;
  logic [15:0]       last_pulse_r, last_pulse_nxt;
  csfd_pkg::status_t status_r, status_nxt;
  csfd_pkg::system_t system_r, system_nxt;
  csfd_pkg::system_t committed_r, committed_nxt;
  logic              parity_r, parity_nxt;
  logic [7:0]        broad_count_r, broad_count_nxt;
  logic [9:0]        line_count_r, line_count_nxt;
  logic [9:0]        first_vis_r, first_vis_nxt;
  logic [9:0]        last_vis_r, last_vis_nxt;
  logic              vis_next_r, vis_next_nxt;
  logic [9:0]        vis_count_r, vis_count_nxt;
  logic [15:0]       frame_errors_r, frame_errors_nxt;
  logic [31:0]       error_total_r, error_total_nxt;
  logic [31:0]       good_frames_r, good_frames_nxt;

  logic [15:0]       pulse;
  logic              err;
  logic              fstart;
  logic              frstart;
  csfd_pkg::system_t sys_sel;
  logic [9:0]        win_first;
  logic [10:0]       win_span;
  logic [10:0]       win_sum;
  logic [9:0]        win_last;

  assign pulse = item.capture_time - last_capture_r;

  always_comb begin
    if (broad_count_r == csfd_pkg::BROAD_PAL) begin
      sys_sel = csfd_pkg::SYS_PAL;
    end else if (broad_count_r == csfd_pkg::BROAD_NTSC) begin
      sys_sel = csfd_pkg::SYS_NTSC;
    end else begin
      sys_sel = system_r;
    end
    win_first = 10'(FIRST_VISIBLE) - {9'd0, parity_r};
    win_span  = (sys_sel == csfd_pkg::SYS_PAL) ? 11'(PAL_VISIBLE - 1) : 11'(NTSC_VISIBLE - 1);
    win_sum   = win_span + {1'b0, win_first};
    win_last  = win_sum[10] ? csfd_pkg::LINE_SAT : win_sum[9:0];
  end

  always_comb begin
    last_capture_nxt = item.capture_time;
    last_pulse_nxt   = pulse;
    status_nxt       = status_r;
    system_nxt       = system_r;
    committed_nxt    = committed_r;
    parity_nxt       = parity_r;
    broad_count_nxt  = broad_count_r;
    line_count_nxt   = line_count_r;
    first_vis_nxt    = first_vis_r;
    last_vis_nxt     = last_vis_r;
    vis_next_nxt     = vis_next_r;
    vis_count_nxt    = vis_count_r;
    frame_errors_nxt = frame_errors_r;
    error_total_nxt  = error_total_r;
    good_frames_nxt  = good_frames_r;
    err              = 1'b0;
    fstart           = 1'b0;
    frstart          = 1'b0;

    if (item.edge_falling) begin
      if (pulse > cfg.half_line_min && pulse < cfg.half_line_max) begin
        if (last_pulse_r > cfg.hsync_min) begin
          unique case (system_r)
            csfd_pkg::SYS_PAL:  parity_nxt = 1'b1;
            csfd_pkg::SYS_NTSC: parity_nxt = 1'b0;
            default:            status_nxt = csfd_pkg::ST_WAIT;
          endcase
        end else begin
          err = 1'b1;
        end
      end
    end else if (pulse < cfg.short_min) begin
      err = 1'b1;
    end else if (pulse < cfg.short_max) begin
      unique case (status_r) inside
        csfd_pkg::ST_WAIT: begin
          status_nxt = csfd_pkg::ST_PRE;
        end
        csfd_pkg::ST_PRE, csfd_pkg::ST_POST: begin
        end
        csfd_pkg::ST_SYNC: begin
          status_nxt = csfd_pkg::ST_POST;
          system_nxt = sys_sel;
          if (sys_sel != csfd_pkg::SYS_UNKNOWN) begin
            first_vis_nxt = win_first;
            last_vis_nxt  = win_last;
          end
        end
        csfd_pkg::ST_LINES: begin
          status_nxt = csfd_pkg::ST_PRE;
          if (parity_r) begin
            if (frame_errors_r == 16'd0) begin
              good_frames_nxt = good_frames_r + 32'd1;
              committed_nxt   = system_r;
            end
            frame_errors_nxt = 16'd0;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end else if (pulse < cfg.hsync_max) begin
      if (vis_next_r && vis_count_r != csfd_pkg::LINE_SAT) begin
        vis_count_nxt = vis_count_r + 10'd1;
      end
      if (status_r == csfd_pkg::ST_POST || status_r == csfd_pkg::ST_LINES) begin
        status_nxt = csfd_pkg::ST_LINES;
        if (line_count_r != csfd_pkg::LINE_SAT) begin
          line_count_nxt = line_count_r + 10'd1;
        end
        vis_next_nxt = (line_count_nxt >= first_vis_r) && (line_count_nxt <= last_vis_r);
      end else begin
        err = 1'b1;
      end
    end else if (pulse >= cfg.broad_min && pulse <= cfg.broad_max) begin
      unique case (status_r) inside
        csfd_pkg::ST_PRE: begin
          status_nxt      = csfd_pkg::ST_SYNC;
          broad_count_nxt = 8'd1;
          parity_nxt      = ~parity_r;
          frstart         = parity_r;
          fstart          = 1'b1;
          line_count_nxt  = 10'd0;
          vis_count_nxt   = 10'd0;
          vis_next_nxt    = 1'b0;
        end
        csfd_pkg::ST_POST: begin
          parity_nxt = 1'b1;
        end
        csfd_pkg::ST_SYNC: begin
          if (broad_count_r != csfd_pkg::BROAD_SAT) begin
            broad_count_nxt = broad_count_r + 8'd1;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end else begin
      err = 1'b1;
    end

    if (err) begin
      if (frame_errors_r != csfd_pkg::FERR_SAT) begin
        frame_errors_nxt = frame_errors_r + 16'd1;
      end
      error_total_nxt = error_total_r + 32'd1;
    end
  end

  always_comb begin
    result.sync_status        = status_nxt;
    result.video_system       = committed_nxt;
    result.field_type         = parity_nxt;
    result.line_number        = line_count_nxt;
    result.next_line_visible  = vis_next_nxt;
    result.visible_line_index = vis_count_nxt;
    result.field_start        = fstart;
    result.frame_start        = frstart;
    result.pulse_error        = err;
    result.valid_frames       = good_frames_nxt;
    result.total_errors       = error_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_capture_r <= 16'd0;
      last_pulse_r   <= 16'd0;
      status_r       <= csfd_pkg::ST_WAIT;
      system_r       <= csfd_pkg::SYS_UNKNOWN;
      committed_r    <= csfd_pkg::SYS_UNKNOWN;
      parity_r       <= 1'b0;
      broad_count_r  <= 8'd0;
      line_count_r   <= 10'd0;
      first_vis_r    <= 10'd0;
      last_vis_r     <= 10'd0;
      vis_next_r     <= 1'b0;
      vis_count_r    <= 10'd0;
      frame_errors_r <= 16'd0;
      error_total_r  <= 32'd0;
      good_frames_r  <= 32'd0;
    end else if (step) begin
      last_capture_r <= last_capture_nxt;
      last_pulse_r   <= last_pulse_nxt;
      status_r       <= status_nxt;
      system_r       <= system_nxt;
      committed_r    <= committed_nxt;
      parity_r       <= parity_nxt;
      broad_count_r  <= broad_count_nxt;
      line_count_r   <= line_count_nxt;
      first_vis_r    <= first_vis_nxt;
      last_vis_r     <= last_vis_nxt;
      vis_next_r     <= vis_next_nxt;
      vis_count_r    <= vis_count_nxt;
      frame_errors_r <= frame_errors_nxt;
      error_total_r  <= error_total_nxt;
      good_frames_r  <= good_frames_nxt;
    end
  end

endmodule

### rtl/composite_sync_field_decoder.sv
// ----------------------------------------------------------------------------
// Composite sync field decoder
// An accepted transaction is held in the input register; when it advances, the core
// updates the field state and the result register, which drives the output channel.
// Throughput: one transaction per cycle unless the result channel stalls; the field state update sets it.
// While a result waits, one further transaction can enter the input register.
// Synchronous reset returns the decoder to waiting and restores the default windows.
// ----------------------------------------------------------------------------
module composite_sync_field_decoder #(
  parameter int unsigned PAL_VISIBLE   = csfd_pkg::PAL_VISIBLE,
  parameter int unsigned NTSC_VISIBLE  = csfd_pkg::NTSC_VISIBLE,
  parameter int unsigned FIRST_VISIBLE = csfd_pkg::FIRST_VISIBLE
) (
  input  logic        clk,
  input  logic        rst_n,
  csfd_in_if.sink     in_ch,
  csfd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  csfd_pkg::cfg_t    cfg_r;
  logic              s1_valid_r;
  csfd_pkg::item_t   s1_item_r;
  logic              out_valid_r;
  csfd_pkg::result_t out_res_r;
  csfd_pkg::result_t core_res;
  logic              advance;
  logic              in_take;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_min     <= csfd_pkg::RST_SHORT_MIN;
      cfg_r.short_max     <= csfd_pkg::RST_SHORT_MAX;
      cfg_r.hsync_min     <= csfd_pkg::RST_HSYNC_MIN;
      cfg_r.hsync_max     <= csfd_pkg::RST_HSYNC_MAX;
      cfg_r.broad_min     <= csfd_pkg::RST_BROAD_MIN;
      cfg_r.broad_max     <= csfd_pkg::RST_BROAD_MAX;
      cfg_r.half_line_min <= csfd_pkg::RST_HALF_LINE_MIN;
      cfg_r.half_line_max <= csfd_pkg::RST_HALF_LINE_MAX;
    end else if (cfg_we) begin
      case (csfd_pkg::cfg_idx_t'(cfg_index))
        csfd_pkg::CFG_SHORT_MIN:     cfg_r.short_min     <= cfg_wdata;
        csfd_pkg::CFG_SHORT_MAX:     cfg_r.short_max     <= cfg_wdata;
        csfd_pkg::CFG_HSYNC_MIN:     cfg_r.hsync_min     <= cfg_wdata;
        csfd_pkg::CFG_HSYNC_MAX:     cfg_r.hsync_max     <= cfg_wdata;
        csfd_pkg::CFG_BROAD_MIN:     cfg_r.broad_min     <= cfg_wdata;
        csfd_pkg::CFG_BROAD_MAX:     cfg_r.broad_max     <= cfg_wdata;
        csfd_pkg::CFG_HALF_LINE_MIN: cfg_r.half_line_min <= cfg_wdata;
        csfd_pkg::CFG_HALF_LINE_MAX: cfg_r.half_line_max <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.edge_falling <= in_ch.edge_falling;
      s1_item_r.capture_time <= in_ch.capture_time;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  csfd_core #(
    .PAL_VISIBLE   (PAL_VISIBLE),
    .NTSC_VISIBLE  (NTSC_VISIBLE),
    .FIRST_VISIBLE (FIRST_VISIBLE)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .result (core_res)
  );

  assign out_ch.valid              = out_valid_r;
  assign out_ch.sync_status        = out_res_r.sync_status;
  assign out_ch.video_system       = out_res_r.video_system;
  assign out_ch.field_type         = out_res_r.field_type;
  assign out_ch.line_number        = out_res_r.line_number;
  assign out_ch.next_line_visible  = out_res_r.next_line_visible;
  assign out_ch.visible_line_index = out_res_r.visible_line_index;
  assign out_ch.field_start        = out_res_r.field_start;
  assign out_ch.frame_start        = out_res_r.frame_start;
  assign out_ch.pulse_error        = out_res_r.pulse_error;
  assign out_ch.valid_frames       = out_res_r.valid_frames;
  assign out_ch.total_errors       = out_res_r.total_errors;

endmodule

### rtl/csfd_checker.sv
// ----------------------------------------------------------------------------
// Composite sync field decoder checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "composite_sync_field_decoder_assert.svh"

module csfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  sync_status,
  input logic        field_type,
  input logic [9:0]  line_number,
  input logic        next_line_visible,
  input logic [9:0]  visible_line_index,
  input logic        field_start,
  input logic        frame_start,
  input logic        pulse_error,
  input logic [31:0] total_errors
);

  // A stalled result transaction must stay on the channel unchanged.
  `CSFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(total_errors) && $stable(sync_status), "result changed while stalled")

  // A frame always opens with the first field.
  `CSFD_ASSERT_NOW(a_frame_in_field, out_valid && frame_start, field_start && !field_type, "frame start without first field start")

  // A field opens in the synchronizing state with its line counters cleared.
  `CSFD_ASSERT_NOW(a_field_open, out_valid && field_start, sync_status == csfd_pkg::ST_SYNC && line_number == 10'd0 && visible_line_index == 10'd0 && !next_line_visible && !pulse_error, "field start with bad state")

endmodule

bind composite_sync_field_decoder csfd_checker u_csfd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .sync_status        (out_ch.sync_status),
  .field_type         (out_ch.field_type),
  .line_number        (out_ch.line_number),
  .next_line_visible  (out_ch.next_line_visible),
  .visible_line_index (out_ch.visible_line_index),
  .field_start        (out_ch.field_start),
  .frame_start        (out_ch.frame_start),
  .pulse_error        (out_ch.pulse_error),
  .total_errors       (out_ch.total_errors)
);

### sim/composite_sync_field_decoder_tb.sv
// ----------------------------------------------------------------------------
// Composite sync field decoder testbench
// Feeds sync edge transactions through the input channel and checks every
// decoded status transaction against an in-bench prediction of the decoder.
// A directed opening walks the sequencer through its special cases. A long
// sync run then pushes the broad counter into saturation. Random PAL and NTSC
// fields, noise and extreme pulse windows follow. Both channels idle at random,
// and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module composite_sync_field_decoder_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SHOW_LIMIT  = 10;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  csfd_in_if  in_ch ();
  csfd_out_if out_ch ();

  composite_sync_field_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Decoder state as predicted by the bench.
  csfd_pkg::cfg_t    win;
  logic [15:0]       prev_capture;
  logic [15:0]       prev_pulse;
  csfd_pkg::status_t phase;
  csfd_pkg::system_t field_system;
  csfd_pkg::system_t shown_system;
  logic              odd_field;
  logic [7:0]        broad_seen;
  logic [9:0]        line_ctr;
  logic [9:0]        win_first;
  logic [9:0]        win_last;
  logic              vis_next;
  logic [9:0]        vis_ctr;
  logic [15:0]       field_errs;
  logic [31:0]       err_total;
  logic [31:0]       good_frame_ctr;
  logic              err_now;

  csfd_pkg::item_t   pending_edges[$];
  csfd_pkg::result_t expected_status[$];
  logic [15:0]       gen_time = '0;

  csfd_pkg::item_t   drv_item = '0;
  logic              drv_busy;
  int                drv_wait;
  int                rcv_wait;
  logic              rcv_go;
  logic              snd_busy = 1'b0;
  logic              rcv_busy = 1'b0;
  logic              hold_go = 1'b0;
  logic              rx_hold;
  csfd_pkg::result_t mon_seen;
  csfd_pkg::result_t mon_want;
  logic              mon_bad;

  int edges_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int field_starts_seen = 0;
  int frame_starts_seen = 0;
  int errors_seen = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic void reset_predictor();
    win.short_min     = csfd_pkg::RST_SHORT_MIN;
    win.short_max     = csfd_pkg::RST_SHORT_MAX;
    win.hsync_min     = csfd_pkg::RST_HSYNC_MIN;
    win.hsync_max     = csfd_pkg::RST_HSYNC_MAX;
    win.broad_min     = csfd_pkg::RST_BROAD_MIN;
    win.broad_max     = csfd_pkg::RST_BROAD_MAX;
    win.half_line_min = csfd_pkg::RST_HALF_LINE_MIN;
    win.half_line_max = csfd_pkg::RST_HALF_LINE_MAX;
    prev_capture   = '0;
    prev_pulse     = '0;
    phase          = csfd_pkg::ST_WAIT;
    field_system   = csfd_pkg::SYS_UNKNOWN;
    shown_system   = csfd_pkg::SYS_UNKNOWN;
    odd_field      = 1'b0;
    broad_seen     = '0;
    line_ctr       = '0;
    win_first      = '0;
    win_last       = '0;
    vis_next       = 1'b0;
    vis_ctr        = '0;
    field_errs     = '0;
    err_total      = '0;
    good_frame_ctr = '0;
    err_now        = 1'b0;
  endfunction

  function automatic void note_error();
    err_now = 1'b1;
    if (field_errs != csfd_pkg::FERR_SAT) field_errs = field_errs + 16'd1;
    err_total = err_total + 32'd1;
  endfunction

  function automatic void place_window();
    int unsigned lo_line;
    int unsigned hi_line;
    if (field_system == csfd_pkg::SYS_PAL) hi_line = csfd_pkg::PAL_VISIBLE - 1;
    else if (field_system == csfd_pkg::SYS_NTSC) hi_line = csfd_pkg::NTSC_VISIBLE - 1;
    else return;
    lo_line = csfd_pkg::FIRST_VISIBLE;
    if (odd_field) lo_line = lo_line - 1;
    lo_line = lo_line & 32'h3FF;
    hi_line = hi_line + lo_line;
    if (hi_line > 1023) hi_line = 1023;
    win_first = lo_line[9:0];
    win_last  = hi_line[9:0];
  endfunction

  function automatic csfd_pkg::result_t decode_edge(csfd_pkg::item_t e);
    logic [15:0]       len;
    logic              field_go;
    logic              frame_go;
    csfd_pkg::result_t r;
    len = e.capture_time - prev_capture;
    field_go = 1'b0;
    frame_go = 1'b0;
    err_now = 1'b0;
    if (e.edge_falling) begin
      if (len > win.half_line_min && len < win.half_line_max) begin
        if (prev_pulse > win.hsync_min) begin
          if (field_system == csfd_pkg::SYS_PAL) odd_field = 1'b1;
          else if (field_system == csfd_pkg::SYS_NTSC) odd_field = 1'b0;
          else phase = csfd_pkg::ST_WAIT;
        end else begin
          note_error();
        end
      end
    end else if (len < win.short_min) begin
      note_error();
    end else if (len < win.short_max) begin
      case (phase)
        csfd_pkg::ST_WAIT: phase = csfd_pkg::ST_PRE;
        csfd_pkg::ST_PRE, csfd_pkg::ST_POST: begin
        end
        csfd_pkg::ST_SYNC: begin
          phase = csfd_pkg::ST_POST;
          if (broad_seen == csfd_pkg::BROAD_PAL) field_system = csfd_pkg::SYS_PAL;
          else if (broad_seen == csfd_pkg::BROAD_NTSC) field_system = csfd_pkg::SYS_NTSC;
          place_window();
        end
        csfd_pkg::ST_LINES: begin
          phase = csfd_pkg::ST_PRE;
          if (odd_field) begin
            if (field_errs == '0) begin
              good_frame_ctr = good_frame_ctr + 32'd1;
              shown_system = field_system;
            end
            field_errs = '0;
          end
        end
        default: note_error();
      endcase
    end else if (len < win.hsync_max) begin
      if (vis_next && vis_ctr != csfd_pkg::LINE_SAT) vis_ctr = vis_ctr + 10'd1;
      if (phase == csfd_pkg::ST_POST || phase == csfd_pkg::ST_LINES) begin
        phase = csfd_pkg::ST_LINES;
        if (line_ctr != csfd_pkg::LINE_SAT) line_ctr = line_ctr + 10'd1;
        vis_next = (line_ctr >= win_first && line_ctr <= win_last);
      end else begin
        note_error();
      end
    end else if (len >= win.broad_min && len <= win.broad_max) begin
      case (phase)
        csfd_pkg::ST_PRE: begin
          phase = csfd_pkg::ST_SYNC;
          broad_seen = 8'd1;
          if (odd_field) begin
            odd_field = 1'b0;
            frame_go = 1'b1;
          end else begin
            odd_field = 1'b1;
          end
          field_go = 1'b1;
          line_ctr = '0;
          vis_ctr = '0;
          vis_next = 1'b0;
        end
        csfd_pkg::ST_POST: odd_field = 1'b1;
        csfd_pkg::ST_SYNC: begin
          if (broad_seen != csfd_pkg::BROAD_SAT) broad_seen = broad_seen + 8'd1;
        end
        default: note_error();
      endcase
    end else begin
      note_error();
    end
    prev_pulse = len;
    prev_capture = e.capture_time;
    r.sync_status        = phase;
    r.video_system       = shown_system;
    r.field_type         = odd_field;
    r.line_number        = line_ctr;
    r.next_line_visible  = vis_next;
    r.visible_line_index = vis_ctr;
    r.field_start        = field_go;
    r.frame_start        = frame_go;
    r.pulse_error        = err_now;
    r.valid_frames       = good_frame_ctr;
    r.total_errors       = err_total;
    return r;
  endfunction

  function automatic void show_result(string tag, csfd_pkg::result_t r);
    $display("  %s st=%0d sys=%0d odd=%0b line=%0d vis=%0b vidx=%0d",
             tag, r.sync_status, r.video_system, r.field_type, r.line_number,
             r.next_line_visible, r.visible_line_index);
    $display("  %s fs=%0b fr=%0b err=%0b good=%0d errs=%0d",
             tag, r.field_start, r.frame_start, r.pulse_error,
             r.valid_frames, r.total_errors);
  endfunction

  function automatic int pick_gap(logic busy);
    if (!busy) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic int pick_len(int lo, int hi);
    if (hi <= lo) return lo;
    return $urandom_range(hi, lo);
  endfunction

  // Edge generation: lengths are relative to the previous capture time.
  function automatic void emit(logic falling, int len);
    csfd_pkg::item_t it;
    gen_time = gen_time + 16'(len);
    it.edge_falling = falling;
    it.capture_time = gen_time;
    pending_edges.push_back(it);
  endfunction

  function automatic void emit_abs(logic falling, logic [15:0] cap);
    csfd_pkg::item_t it;
    gen_time = cap;
    it.edge_falling = falling;
    it.capture_time = cap;
    pending_edges.push_back(it);
  endfunction

  function automatic void emit_noise();
    emit_abs(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
  endfunction

  function automatic int short_len();
    return pick_len(int'(win.short_min), int'(win.short_max) - 1);
  endfunction

  function automatic int hsync_len();
    int lo;
    lo = int'(win.short_max);
    if (int'(win.hsync_min) + 1 > lo) lo = int'(win.hsync_min) + 1;
    return pick_len(lo, int'(win.hsync_max) - 1);
  endfunction

  function automatic int broad_len();
    return pick_len(int'(win.broad_min), int'(win.broad_max));
  endfunction

  function automatic int wide_gap();
    return pick_len(int'(win.half_line_max), int'(win.half_line_max) + 1500);
  endfunction

  function automatic int half_gap();
    return pick_len(int'(win.half_line_min) + 1, int'(win.half_line_max) - 1);
  endfunction

  function automatic void gen_field(int n_lines, logic noisy);
    int n_broad;
    int n_pre;
    int n_post;
    n_pre  = $urandom_range(1, 6);
    n_post = $urandom_range(1, 6);
    for (int i = 0; i < n_pre; i++) begin
      emit(1'b1, wide_gap());
      emit(1'b0, short_len());
      if (noisy && $urandom_range(0, 9) == 0) emit_noise();
    end
    case ($urandom_range(0, 9))
      0: n_broad = $urandom_range(0, 9);
      1, 2, 3, 4, 5: n_broad = int'(csfd_pkg::BROAD_PAL);
      default: n_broad = int'(csfd_pkg::BROAD_NTSC);
    endcase
    for (int i = 0; i < n_broad; i++) begin
      emit(1'b1, pick_len(150, 450));
      emit(1'b0, broad_len());
      if (noisy && $urandom_range(0, 9) == 0) emit_noise();
    end
    for (int i = 0; i < n_post; i++) begin
      emit(1'b1, wide_gap());
      emit(1'b0, short_len());
      if (i == 0 && $urandom_range(0, 5) == 0) begin
        emit(1'b1, pick_len(150, 450));
        emit(1'b0, broad_len());
      end
    end
    for (int i = 0; i < n_lines; i++) begin
      if ($urandom_range(0, 14) == 0) emit(1'b1, half_gap());
      else emit(1'b1, wide_gap());
      emit(1'b0, hsync_len());
      if (noisy && $urandom_range(0, 14) == 0) emit_noise();
    end
  endfunction

  function automatic void gen_fields(int target);
    while (pending_edges.size() < target) begin
      gen_field($urandom_range(3, 40), $urandom_range(0, 3) == 0);
    end
  endfunction

  function automatic csfd_pkg::cfg_t sane_windows();
    csfd_pkg::cfg_t c;
    c.short_min     = 16'($urandom_range(100, 140));
    c.short_max     = 16'($urandom_range(260, 299));
    c.hsync_min     = 16'($urandom_range(300, 320));
    c.hsync_max     = 16'($urandom_range(480, 520));
    c.broad_min     = 16'($urandom_range(1700, 1900));
    c.broad_max     = 16'($urandom_range(2400, 2600));
    c.half_line_min = 16'($urandom_range(1200, 1300));
    c.half_line_max = 16'($urandom_range(2200, 2399));
    return c;
  endfunction

  task automatic write_reg(csfd_pkg::cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      csfd_pkg::CFG_SHORT_MIN:     win.short_min = val;
      csfd_pkg::CFG_SHORT_MAX:     win.short_max = val;
      csfd_pkg::CFG_HSYNC_MIN:     win.hsync_min = val;
      csfd_pkg::CFG_HSYNC_MAX:     win.hsync_max = val;
      csfd_pkg::CFG_BROAD_MIN:     win.broad_min = val;
      csfd_pkg::CFG_BROAD_MAX:     win.broad_max = val;
      csfd_pkg::CFG_HALF_LINE_MIN: win.half_line_min = val;
      csfd_pkg::CFG_HALF_LINE_MAX: win.half_line_max = val;
      default: begin
      end
    endcase
  endtask

  task automatic load_windows(csfd_pkg::cfg_t c);
    write_reg(csfd_pkg::CFG_SHORT_MIN, c.short_min);
    write_reg(csfd_pkg::CFG_SHORT_MAX, c.short_max);
    write_reg(csfd_pkg::CFG_HSYNC_MIN, c.hsync_min);
    write_reg(csfd_pkg::CFG_HSYNC_MAX, c.hsync_max);
    write_reg(csfd_pkg::CFG_BROAD_MIN, c.broad_min);
    write_reg(csfd_pkg::CFG_BROAD_MAX, c.broad_max);
    write_reg(csfd_pkg::CFG_HALF_LINE_MIN, c.half_line_min);
    write_reg(csfd_pkg::CFG_HALF_LINE_MAX, c.half_line_max);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_edges.size() != 0 || in_ch.valid || expected_status.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      drv_wait = 0;
    end else begin
      drv_busy = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        expected_status.push_back(decode_edge(drv_item));
        edges_sent++;
        drv_busy = 1'b0;
        drv_wait = pick_gap(snd_busy);
      end
      if (!drv_busy) begin
        if (drv_wait > 0) begin
          drv_wait--;
        end else if (pending_edges.size() > 0) begin
          drv_item = pending_edges.pop_front();
          drv_busy = 1'b1;
        end
      end
      in_ch.valid <= drv_busy;
      in_ch.edge_falling <= drv_item.edge_falling;
      in_ch.capture_time <= drv_item.capture_time;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rcv_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        mon_seen.sync_status        = csfd_pkg::status_t'(out_ch.sync_status);
        mon_seen.video_system       = csfd_pkg::system_t'(out_ch.video_system);
        mon_seen.field_type         = out_ch.field_type;
        mon_seen.line_number        = out_ch.line_number;
        mon_seen.next_line_visible  = out_ch.next_line_visible;
        mon_seen.visible_line_index = out_ch.visible_line_index;
        mon_seen.field_start        = out_ch.field_start;
        mon_seen.frame_start        = out_ch.frame_start;
        mon_seen.pulse_error        = out_ch.pulse_error;
        mon_seen.valid_frames       = out_ch.valid_frames;
        mon_seen.total_errors       = out_ch.total_errors;
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("Status transaction %0d arrived with nothing expected.", results_seen);
        end else begin
          mon_want = expected_status.pop_front();
          mon_bad = (mon_seen.sync_status !== mon_want.sync_status)
                 || (mon_seen.video_system !== mon_want.video_system)
                 || (mon_seen.field_type !== mon_want.field_type)
                 || (mon_seen.line_number !== mon_want.line_number)
                 || (mon_seen.next_line_visible !== mon_want.next_line_visible)
                 || (mon_seen.visible_line_index !== mon_want.visible_line_index)
                 || (mon_seen.field_start !== mon_want.field_start)
                 || (mon_seen.frame_start !== mon_want.frame_start)
                 || (mon_seen.pulse_error !== mon_want.pulse_error)
                 || (mon_seen.valid_frames !== mon_want.valid_frames)
                 || (mon_seen.total_errors !== mon_want.total_errors);
          if (mon_bad) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT) begin
              $display("Mismatch on status transaction %0d.", results_seen);
              show_result("expected", mon_want);
              show_result("actual  ", mon_seen);
            end
          end
        end
        if (mon_seen.field_start === 1'b1) field_starts_seen++;
        if (mon_seen.frame_start === 1'b1) frame_starts_seen++;
        if (mon_seen.pulse_error === 1'b1) errors_seen++;
        rcv_wait = pick_gap(rcv_busy);
      end
      if (rcv_wait > 0) begin
        rcv_wait--;
        rcv_go = 1'b0;
      end else begin
        rcv_go = 1'b1;
      end
      out_ch.ready <= rcv_go && !rx_hold;
    end
  end

  // The receiver holds off once for a long stretch while edges keep coming.
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("composite_sync_field_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.edge_falling = 1'b0;
    in_ch.capture_time = '0;
    out_ch.ready = 1'b0;
    reset_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk through the sequencer with the default windows.
    snd_busy = 1'b1;
    rcv_busy = 1'b1;
    emit(1'b0, 0);
    emit(1'b0, 200);
    emit(1'b1, 2000);
    emit(1'b0, 400);
    emit(1'b1, 1500);
    emit(1'b0, 2000);
    emit(1'b0, 200);
    repeat (5) emit(1'b0, 2000);
    emit(1'b0, 200);
    emit(1'b0, 200);
    emit(1'b0, 2000);
    emit(1'b0, 400);
    emit(1'b1, 1500);
    emit(1'b0, 400);
    emit(1'b0, 600);
    emit(1'b0, 3000);
    emit(1'b0, 200);
    repeat (6) emit(1'b0, 2000);
    emit(1'b0, 200);
    emit(1'b0, 400);
    emit(1'b1, 1500);
    emit_abs(1'b1, 16'hFFFF);
    emit(1'b0, 200);
    wait_idle();

    // One long sync run that saturates the broad counter.
    snd_busy = 1'b0;
    rcv_busy = 1'b0;
    load_windows(sane_windows());
    emit(1'b1, wide_gap());
    emit(1'b0, short_len());
    repeat (258) emit(1'b0, broad_len());
    emit(1'b0, short_len());
    repeat (12) emit(1'b0, hsync_len());
    emit(1'b0, short_len());
    wait_idle();

    snd_busy = 1'b1;
    rcv_busy = 1'b1;
    load_windows(sane_windows());
    hold_go = 1'b1;
    gen_fields(100);
    wait_idle();

    load_windows({8{16'h0000}});
    repeat (20) emit_noise();
    wait_idle();
    rcv_busy = 1'b0;
    load_windows({8{16'hFFFF}});
    repeat (20) emit_noise();
    wait_idle();
    snd_busy = 1'b0;
    rcv_busy = 1'b1;
    load_windows({4{16'h0000, 16'hFFFF}});
    repeat (20) emit_noise();
    wait_idle();
    load_windows({4{16'hFFFF, 16'h0000}});
    repeat (20) emit_noise();
    wait_idle();

    load_windows(sane_windows());
    gen_fields(40);
    wait_idle();
    snd_busy = 1'b1;
    rcv_busy = 1'b0;
    gen_fields(40);
    wait_idle();
    repeat (8) @(posedge clk);

    if (expected_status.size() != 0) mismatches += expected_status.size();
    $display("Run covered %0d edge transactions over eight window settings.", edges_sent);
    $display("It saw %0d field starts, %0d frame starts, %0d pulse errors, %0d mismatches.",
             field_starts_seen, frame_starts_seen, errors_seen, mismatches);
    if (mismatches == 0) begin
      $display("composite_sync_field_decoder regression: pass");
    end else begin
      $display("composite_sync_field_decoder regression: fail");
    end
    $finish;
  end

endmodule
